>>> src/assert_macros.svh
// Assertion macros shared by the clock frame replacement RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: check failed");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

`endif

>>> src/clfr_pkg.sv
// Shared types and constants of the clock frame replacement block.
// Used by clfr_datapath, clfr_ctrl and clock_frame_replacement_core.
package clfr_pkg;

   localparam int FRAMES = 64;
   localparam int SLOT_W = 6;
   localparam int CNT_W  = 7;
   localparam int TAG_W  = 20;
   localparam int KIND_W = 2;
   localparam int GRD_W  = CNT_W + 1;

   localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd64;

   localparam logic [1:0] REQ_ALLOC  = 2'd0;
   localparam logic [1:0] REQ_ACCESS = 2'd1;
   localparam logic [1:0] REQ_FREE   = 2'd2;

   localparam logic [KIND_W-1:0] KIND_FILE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SWAP = 2'd2;

   localparam logic [1:0] ACT_DISCARD   = 2'd0;
   localparam logic [1:0] ACT_WRITEBACK = 2'd1;
   localparam logic [1:0] ACT_SWAP      = 2'd2;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_IGNORED = 1'b1;

   typedef struct packed {
      logic latch_req;
      logic mark_ignored;
      logic mark_noframe;
      logic access;
      logic scan_next;
      logic pick_scan;
      logic pick_slot;
      logic pick_hand;
      logic rd_slot;
      logic sweep_init;
      logic step_direct;
      logic step_load;
      logic sweep_clear;
      logic unlink;
      logic append;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       slot_in_use;
      logic       scan_end;
      logic       scan_free;
      logic       ring_empty;
      logic       direct_step;
      logic       hand_ref;
      logic       guard_zero;
      logic       out_ready;
   } sts_type;

endpackage

>>> src/clfr_datapath.sv
// Datapath of the clock frame replacement block: slot flags, ring links,
// page memories, clock hand and result register. Depends on clfr_pkg.
`include "assert_macros.svh"

module clfr_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    req_type,
   input  logic [clfr_pkg::SLOT_W-1:0]   req_slot,
   input  logic                          req_is_write,
   input  logic [clfr_pkg::TAG_W-1:0]    req_page_tag,
   input  logic [clfr_pkg::KIND_W-1:0]   req_page_kind,
   input  logic                          csr_wr_en,
   input  logic [clfr_pkg::CNT_W-1:0]    csr_wr_data,
   input  logic                          rsp_stall,
   input  clfr_pkg::cmd_type             cmd,
   output clfr_pkg::sts_type             sts,
   output logic                          rsp_valid,
   output logic                          rsp_status,
   output logic [clfr_pkg::SLOT_W-1:0]   rsp_result_slot,
   output logic                          rsp_evicted,
   output logic [clfr_pkg::TAG_W-1:0]    rsp_victim_tag,
   output logic [1:0]                    rsp_victim_action
);

   localparam int PAGE_W = clfr_pkg::KIND_W + clfr_pkg::TAG_W;

   logic [clfr_pkg::SLOT_W-1:0] next_mem [clfr_pkg::FRAMES];
   logic [clfr_pkg::SLOT_W-1:0] prev_mem [clfr_pkg::FRAMES];
   logic [PAGE_W-1:0]           page_mem [clfr_pkg::FRAMES];

   logic [clfr_pkg::SLOT_W-1:0] next_q_ff, prev_q_ff;
   logic [PAGE_W-1:0]           page_q_ff;

   logic [clfr_pkg::CNT_W-1:0]  frame_limit_ff, frame_limit_in;
   logic [1:0]                  type_ff, type_in;
   logic [clfr_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic                        write_ff, write_in;
   logic [clfr_pkg::TAG_W-1:0]  tag_ff, tag_in;
   logic [clfr_pkg::KIND_W-1:0] kind_ff, kind_in;

   logic [clfr_pkg::FRAMES-1:0] in_use_ff, in_use_in;
   logic [clfr_pkg::FRAMES-1:0] ref_ff, ref_in;
   logic [clfr_pkg::FRAMES-1:0] mod_ff, mod_in;
   logic [clfr_pkg::SLOT_W-1:0] head_ff, head_in;
   logic [clfr_pkg::SLOT_W-1:0] tail_ff, tail_in;
   logic [clfr_pkg::SLOT_W-1:0] hand_ff, hand_in;
   logic                        hand_valid_ff, hand_valid_in;
   logic [clfr_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [clfr_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [clfr_pkg::GRD_W-1:0]  guard_ff, guard_in;
   logic [clfr_pkg::SLOT_W-1:0] pick_ff, pick_in;
   logic                        evict_ff, evict_in;

   logic                        res_status_ff, res_status_in;
   logic [clfr_pkg::SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic                        res_evicted_ff, res_evicted_in;
   logic [clfr_pkg::TAG_W-1:0]  res_vtag_ff, res_vtag_in;
   logic [1:0]                  res_vact_ff, res_vact_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_status_ff;
   logic [clfr_pkg::SLOT_W-1:0] rsp_slot_ff;
   logic                        rsp_evicted_ff;
   logic [clfr_pkg::TAG_W-1:0]  rsp_vtag_ff;
   logic [1:0]                  rsp_vact_ff;

   logic [clfr_pkg::CNT_W-1:0]  limit;
   logic                        at_head, at_tail, multi;
   logic [clfr_pkg::KIND_W-1:0] vkind;
   logic [clfr_pkg::SLOT_W-1:0] rd_addr;
   logic                        next_we, prev_we;
   logic [clfr_pkg::SLOT_W-1:0] next_wa, next_wd, prev_wa, prev_wd;

   assign limit   = (frame_limit_ff > clfr_pkg::CNT_W'(clfr_pkg::FRAMES)) ?
                    clfr_pkg::CNT_W'(clfr_pkg::FRAMES) : frame_limit_ff;
   assign at_head = (pick_ff == head_ff);
   assign at_tail = (pick_ff == tail_ff);
   assign multi   = (count_ff > clfr_pkg::CNT_W'(1));
   assign vkind   = page_q_ff[PAGE_W-1 -: clfr_pkg::KIND_W];
   assign rd_addr = cmd.rd_slot ? slot_ff : hand_ff;

   always_comb begin
      frame_limit_in = frame_limit_ff;
      type_in        = type_ff;
      slot_in        = slot_ff;
      write_in       = write_ff;
      tag_in         = tag_ff;
      kind_in        = kind_ff;
      in_use_in      = in_use_ff;
      ref_in         = ref_ff;
      mod_in         = mod_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      hand_in        = hand_ff;
      hand_valid_in  = hand_valid_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      guard_in       = guard_ff;
      pick_in        = pick_ff;
      evict_in       = evict_ff;
      res_status_in  = res_status_ff;
      res_slot_in    = res_slot_ff;
      res_evicted_in = res_evicted_ff;
      res_vtag_in    = res_vtag_ff;
      res_vact_in    = res_vact_ff;

      if (csr_wr_en) begin
         frame_limit_in = csr_wr_data;
      end
      if (cmd.latch_req) begin
         type_in        = req_type;
         slot_in        = req_slot;
         write_in       = req_is_write;
         tag_in         = req_page_tag;
         kind_in        = req_page_kind;
         idx_in         = '0;
         evict_in       = 1'b0;
         res_status_in  = clfr_pkg::STATUS_DONE;
         res_slot_in    = req_slot;
         res_evicted_in = 1'b0;
         res_vtag_in    = '0;
         res_vact_in    = clfr_pkg::ACT_DISCARD;
      end
      if (cmd.mark_ignored) begin
         res_status_in = clfr_pkg::STATUS_IGNORED;
      end
      if (cmd.mark_noframe) begin
         res_status_in = clfr_pkg::STATUS_IGNORED;
         res_slot_in   = '0;
      end
      if (cmd.access) begin
         ref_in[slot_ff] = 1'b1;
         if (write_ff) begin
            mod_in[slot_ff] = 1'b1;
         end
      end
      if (cmd.scan_next) begin
         idx_in = idx_ff + clfr_pkg::CNT_W'(1);
      end
      if (cmd.pick_scan) begin
         pick_in = idx_ff[clfr_pkg::SLOT_W-1:0];
      end
      if (cmd.pick_slot) begin
         pick_in  = slot_ff;
         evict_in = 1'b0;
      end
      if (cmd.pick_hand) begin
         pick_in  = hand_ff;
         evict_in = 1'b1;
      end
      if (cmd.sweep_init) begin
         guard_in = {count_ff, 1'b1};
      end
      if (cmd.step_direct) begin
         hand_in       = head_ff;
         hand_valid_in = 1'b1;
      end
      if (cmd.step_load) begin
         hand_in = next_q_ff;
      end
      if (cmd.sweep_clear) begin
         ref_in[hand_ff] = 1'b0;
         guard_in        = guard_ff - clfr_pkg::GRD_W'(1);
      end
      if (cmd.unlink) begin
         if (evict_ff) begin
            res_evicted_in = 1'b1;
            res_vtag_in    = page_q_ff[clfr_pkg::TAG_W-1:0];
            if (vkind == clfr_pkg::KIND_SWAP) begin
               res_vact_in = clfr_pkg::ACT_SWAP;
            end else if (mod_ff[pick_ff]) begin
               res_vact_in = (vkind == clfr_pkg::KIND_FILE) ?
                             clfr_pkg::ACT_WRITEBACK : clfr_pkg::ACT_SWAP;
            end else begin
               res_vact_in = clfr_pkg::ACT_DISCARD;
            end
         end
         if (hand_valid_ff && hand_ff == pick_ff) begin
            if (at_tail) begin
               hand_valid_in = 1'b0;
            end else begin
               hand_in = next_q_ff;
            end
         end
         if (!multi) begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
         end else begin
            if (at_head) begin
               head_in = next_q_ff;
            end
            if (at_tail) begin
               tail_in = prev_q_ff;
            end
            count_in = count_ff - clfr_pkg::CNT_W'(1);
         end
         in_use_in[pick_ff] = 1'b0;
         ref_in[pick_ff]    = 1'b0;
         mod_in[pick_ff]    = 1'b0;
      end
      if (cmd.append) begin
         in_use_in[pick_ff] = 1'b1;
         ref_in[pick_ff]    = 1'b0;
         mod_in[pick_ff]    = 1'b0;
         if (count_ff == '0) begin
            head_in = pick_ff;
         end
         tail_in     = pick_ff;
         count_in    = count_ff + clfr_pkg::CNT_W'(1);
         res_slot_in = pick_ff;
      end
   end

   always_comb begin
      next_we = 1'b0;
      next_wa = prev_q_ff;
      next_wd = next_q_ff;
      prev_we = 1'b0;
      prev_wa = next_q_ff;
      prev_wd = prev_q_ff;
      if (cmd.unlink && multi) begin
         next_we = !at_head;
         prev_we = !at_tail;
      end
      if (cmd.append) begin
         next_we = (count_ff != '0);
         next_wa = tail_ff;
         next_wd = pick_ff;
         prev_we = 1'b1;
         prev_wa = pick_ff;
         prev_wd = (count_ff == '0) ? pick_ff : tail_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (cmd.append) begin
         page_mem[pick_ff] <= {kind_ff, tag_ff};
      end
      next_q_ff <= next_mem[rd_addr];
      prev_q_ff <= prev_mem[rd_addr];
      page_q_ff <= page_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff <= clfr_pkg::LIMIT_RESET;
         in_use_ff      <= '0;
         ref_ff         <= '0;
         mod_ff         <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         hand_ff        <= '0;
         hand_valid_ff  <= 1'b0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         frame_limit_ff <= frame_limit_in;
         in_use_ff      <= in_use_in;
         ref_ff         <= ref_in;
         mod_ff         <= mod_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         hand_ff        <= hand_in;
         hand_valid_ff  <= hand_valid_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff        <= type_in;
      slot_ff        <= slot_in;
      write_ff       <= write_in;
      tag_ff         <= tag_in;
      kind_ff        <= kind_in;
      idx_ff         <= idx_in;
      guard_ff       <= guard_in;
      pick_ff        <= pick_in;
      evict_ff       <= evict_in;
      res_status_ff  <= res_status_in;
      res_slot_ff    <= res_slot_in;
      res_evicted_ff <= res_evicted_in;
      res_vtag_ff    <= res_vtag_in;
      res_vact_ff    <= res_vact_in;
      if (cmd.emit) begin
         rsp_status_ff  <= res_status_ff;
         rsp_slot_ff    <= res_slot_ff;
         rsp_evicted_ff <= res_evicted_ff;
         rsp_vtag_ff    <= res_vtag_ff;
         rsp_vact_ff    <= res_vact_ff;
      end
   end

   assign sts.req_type    = type_ff;
   assign sts.slot_in_use = in_use_ff[slot_ff];
   assign sts.scan_end    = (idx_ff >= limit);
   assign sts.scan_free   = !in_use_ff[idx_ff[clfr_pkg::SLOT_W-1:0]];
   assign sts.ring_empty  = (count_ff == '0);
   assign sts.direct_step = !hand_valid_ff || (hand_ff == tail_ff);
   assign sts.hand_ref    = ref_ff[hand_ff];
   assign sts.guard_zero  = (guard_ff == '0);
   assign sts.out_ready   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_slot   = rsp_slot_ff;
   assign rsp_evicted       = rsp_evicted_ff;
   assign rsp_victim_tag    = rsp_vtag_ff;
   assign rsp_victim_action = rsp_vact_ff;

   `ASSERT_ALWAYS(a_count_matches, clock, reset, $countones(in_use_ff) == int'(count_ff))
   `ASSERT_IMPLY(a_hand_in_ring, clock, reset, hand_valid_ff, count_ff != '0)
   `ASSERT_IMPLY(a_append_free, clock, reset, cmd.append, !in_use_ff[pick_ff])
   `ASSERT_IMPLY(a_unlink_used, clock, reset, cmd.unlink, in_use_ff[pick_ff])

endmodule

>>> src/clfr_ctrl.sv
// Sequencer of the clock frame replacement block: free-slot scan, clock
// sweep, unlink and append steps. Depends on clfr_pkg.
module clfr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  clfr_pkg::sts_type sts,
   output clfr_pkg::cmd_type cmd
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_DECODE = 9'b000000010,
      ST_SCAN   = 9'b000000100,
      ST_STEP   = 9'b000001000,
      ST_WAIT   = 9'b000010000,
      ST_TEST   = 9'b000100000,
      ST_UNLINK = 9'b001000000,
      ST_APPEND = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority case (sts.req_type)
               clfr_pkg::REQ_ALLOC: begin
                  state_in = ST_SCAN;
               end
               clfr_pkg::REQ_ACCESS: begin
                  cmd.access       = sts.slot_in_use;
                  cmd.mark_ignored = !sts.slot_in_use;
                  state_in         = ST_FINISH;
               end
               clfr_pkg::REQ_FREE: begin
                  if (sts.slot_in_use) begin
                     cmd.pick_slot = 1'b1;
                     cmd.rd_slot   = 1'b1;
                     state_in      = ST_UNLINK;
                  end else begin
                     cmd.mark_ignored = 1'b1;
                     state_in         = ST_FINISH;
                  end
               end
               default: begin
                  cmd.mark_ignored = 1'b1;
                  state_in         = ST_FINISH;
               end
            endcase
         end
         ST_SCAN: begin
            if (sts.scan_end) begin
               if (sts.ring_empty) begin
                  cmd.mark_noframe = 1'b1;
                  state_in         = ST_FINISH;
               end else begin
                  cmd.sweep_init = 1'b1;
                  state_in       = ST_STEP;
               end
            end else if (sts.scan_free) begin
               cmd.pick_scan = 1'b1;
               state_in      = ST_APPEND;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_STEP: begin
            if (sts.direct_step) begin
               cmd.step_direct = 1'b1;
               state_in        = ST_TEST;
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            cmd.step_load = 1'b1;
            state_in      = ST_TEST;
         end
         ST_TEST: begin
            if (sts.hand_ref && !sts.guard_zero) begin
               cmd.sweep_clear = 1'b1;
               state_in        = ST_STEP;
            end else begin
               cmd.pick_hand = 1'b1;
               state_in      = ST_UNLINK;
            end
         end
         ST_UNLINK: begin
            cmd.unlink = 1'b1;
            state_in   = (sts.req_type == clfr_pkg::REQ_ALLOC) ? ST_APPEND : ST_FINISH;
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

>>> src/clock_frame_replacement_core.sv
// Clock (second-chance) frame replacement over 64 slots kept in allocation
// order. One transaction is worked at a time; a result waits in an output
// register while the next transaction is taken. Access and ignored requests
// pass through decode and finish; a free adds an unlink step. An allocate
// scans one slot per cycle from slot 0 for the lowest free slot below the
// frame limit, then, with nothing free, sweeps the hand: each step either
// moves the hand to the ring head or loads the next link through the
// registered link memory read, for at most frames in use + 1 steps, since
// one pass clears every referenced frame, followed by unlink and append.
// Depends on clfr_pkg, clfr_ctrl and clfr_datapath.
module clock_frame_replacement_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic [clfr_pkg::SLOT_W-1:0]   req_slot,
   input  logic                          req_is_write,
   input  logic [clfr_pkg::TAG_W-1:0]    req_page_tag,
   input  logic [clfr_pkg::KIND_W-1:0]   req_page_kind,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_status,
   output logic [clfr_pkg::SLOT_W-1:0]   rsp_result_slot,
   output logic                          rsp_evicted,
   output logic [clfr_pkg::TAG_W-1:0]    rsp_victim_tag,
   output logic [1:0]                    rsp_victim_action,
   input  logic                          csr_wr_en,
   input  logic [clfr_pkg::CNT_W-1:0]    csr_wr_data
);

   clfr_pkg::cmd_type cmd;
   clfr_pkg::sts_type sts;

   clfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   clfr_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_type          (req_type),
      .req_slot          (req_slot),
      .req_is_write      (req_is_write),
      .req_page_tag      (req_page_tag),
      .req_page_kind     (req_page_kind),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_stall         (rsp_stall),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_result_slot   (rsp_result_slot),
      .rsp_evicted       (rsp_evicted),
      .rsp_victim_tag    (rsp_victim_tag),
      .rsp_victim_action (rsp_victim_action)
   );

endmodule
